// ===== src/landmark_map_associator_top_macros.svh =====
// Assertion macros for the landmark map associator checker.
// Depends on nothing; included by the checker file only.
`ifndef LANDMARK_MAP_ASSOCIATOR_TOP_MACROS_SVH
`define LANDMARK_MAP_ASSOCIATOR_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LMA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define LMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/lma_pkg.sv =====
// Shared constants, types and the quarter-wave sine function of the map associator.
// Depends on nothing; used by every module of the block but lma_ram.
`default_nettype none
package lma_pkg;
   localparam int MAP_DEPTH = 256;
   localparam int SINE_ENTRIES = 1024;
   localparam int IDX_W = $clog2(MAP_DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam int SIDX_W = $clog2(SINE_ENTRIES);
   // Quarter-wave table: one entry per table step in the first quadrant.
   localparam int QTAB_N = SINE_ENTRIES / 4;
   localparam int QIDX_W = SIDX_W - 2;
   localparam int QSTEP = 16384 / QTAB_N;

   localparam logic [1:0] STATUS_MATCH = 2'd0;
   localparam logic [1:0] STATUS_NEW = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [0:0] CMD_POSE = 1'b0;
   localparam logic [0:0] CMD_POINT = 1'b1;

   localparam logic [0:0] CSR_SENSOR_OFFSET = 1'b0;
   localparam logic [0:0] CSR_MATCH_DIST_SQ = 1'b1;

   localparam logic [23:0] MATCH_DIST_RESET = 24'd65536;

   // One point passed from the front to the back through the queue.
   typedef struct packed {
      logic signed [23:0] gx;
      logic signed [23:0] gy;
      logic signed [17:0] pz;
      logic signed [18:0] bx;
      logic signed [17:0] by;
      logic               fend;
   } point_type;

   // Evaluated only with constant arguments, to fill the quarter-wave table.
   function automatic logic signed [15:0] quarter_sine(input logic [14:0] t);
      logic signed [63:0] t2, r, s;
      begin
         t2 = (64'(t) * 64'(t)) >>> 14;
         r = 64'sd43068;
         r = 64'sd1256749 - ((r * t2) >>> 14);
         r = 64'sd21392327 - ((r * t2) >>> 14);
         r = 64'sd173399667 - ((r * t2) >>> 14);
         r = 64'sd421657428 - ((r * t2) >>> 14);
         s = (r * 64'(t) + (64'sd1 <<< 27)) >>> 28;
         if (s > 64'sd16384) s = 64'sd16384;
         quarter_sine = 16'(s);
      end
   endfunction

   // Sine at a quarter turn, the one value the table does not hold.
   localparam logic signed [15:0] QS_TOP = quarter_sine(15'd16384);
endpackage
`default_nettype wire

// ===== src/lma_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`default_nettype none
module lma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/lma_front.sv =====
// Front end: pose register, sine lookup, rotation and translation of points.
// Depends on lma_pkg.
`default_nettype none
module lma_front import lma_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic               req_cmd,
   input  wire logic signed [23:0] req_pose_x,
   input  wire logic signed [23:0] req_pose_y,
   input  wire logic        [15:0] req_heading,
   input  wire logic signed [17:0] req_point_x,
   input  wire logic signed [17:0] req_point_y,
   input  wire logic signed [17:0] req_point_z,
   input  wire logic               req_frame_end,
   input  wire logic        [10:0] sensor_offset,
   output logic                    q_push,
   input  wire logic               q_full,
   output point_type               q_data
);
   typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM} state_type;
   state_type state_ff;
   logic signed [23:0] vx_ff, vy_ff;
   logic [SIDX_W-1:0] sidx_ff;
   logic pose_valid_ff;
   logic signed [15:0] sin_ff, cos_ff;
   logic signed [18:0] bx_ff;
   logic signed [17:0] by_ff, pz_ff;
   logic fend_ff;
   logic signed [35:0] bxc_ff, bys_ff, bxs_ff, byc_ff;
   logic signed [37:0] sum_x, sum_y;
   logic signed [24:0] rx, ry;
   logic signed [25:0] gx_w, gy_w;
   logic [SIDX_W-1:0] sidx_in;
   logic signed [15:0] qtab [QTAB_N];

   // Constant first-quadrant sine table, Q14.
   for (genvar k = 0; k < QTAB_N; k++) begin : g_qtab
      assign qtab[k] = quarter_sine(15'(k * QSTEP));
   end

   // Full-turn sine from the quarter-wave table, folded by quadrant.
   function automatic logic signed [15:0] sine_lookup(input logic [SIDX_W-1:0] ix);
      logic [QIDX_W-1:0] k, k_neg;
      logic signed [15:0] s;
      k = ix[QIDX_W-1:0];
      k_neg = -k;
      if (!ix[SIDX_W-2]) s = qtab[k];
      else if (k == '0) s = QS_TOP;
      else s = qtab[k_neg];
      sine_lookup = ix[SIDX_W-1] ? -s : s;
   endfunction

   assign req_full = (state_ff != S_IDLE);
   assign sidx_in = req_heading[15 -: SIDX_W];

   assign sum_x = 38'(bxc_ff) - 38'(bys_ff) + 38'sd8192;
   assign sum_y = 38'(bxs_ff) + 38'(byc_ff) + 38'sd8192;
   assign rx = 25'(sum_x >>> 14);
   assign ry = 25'(sum_y >>> 14);
   assign gx_w = 26'(vx_ff) + 26'(rx);
   assign gy_w = 26'(vy_ff) + 26'(ry);

   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      if (v > 26'sd8388607) sat24 = 24'sh7FFFFF;
      else if (v < -26'sd8388608) sat24 = 24'sh800000;
      else sat24 = 24'(v);
   endfunction

   assign q_push = (state_ff == S_SUM) && !q_full;
   always_comb begin
      q_data.gx = sat24(gx_w);
      q_data.gy = sat24(gy_w);
      q_data.pz = pz_ff;
      q_data.bx = bx_ff;
      q_data.by = by_ff;
      q_data.fend = fend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pose_valid_ff <= 1'b0;
         vx_ff <= '0;
         vy_ff <= '0;
         sidx_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_push) begin
                  if (req_cmd == CMD_POSE) begin
                     vx_ff <= req_pose_x;
                     vy_ff <= req_pose_y;
                     sidx_ff <= sidx_in;
                     pose_valid_ff <= 1'b1;
                  end else if (pose_valid_ff) begin
                     sin_ff <= sine_lookup(sidx_ff);
                     cos_ff <= sine_lookup(sidx_ff + SIDX_W'(SINE_ENTRIES / 4));
                     bx_ff <= 19'(req_point_x) + 19'(sensor_offset);
                     by_ff <= req_point_y;
                     pz_ff <= req_point_z;
                     fend_ff <= req_frame_end;
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               bxc_ff <= 36'(bx_ff) * 36'(cos_ff);
               bys_ff <= 36'(by_ff) * 36'(sin_ff);
               bxs_ff <= 36'(bx_ff) * 36'(sin_ff);
               byc_ff <= 36'(by_ff) * 36'(cos_ff);
               state_ff <= S_SUM;
            end
            S_SUM: if (!q_full) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== src/lma_queue.sv =====
// Two-entry queue between the front end and the map search.
// Depends on lma_pkg.
`default_nettype none
module lma_queue import lma_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   output logic           full,
   input  wire point_type wdata,
   input  wire logic      pop,
   output logic           empty,
   output point_type      rdata
);
   point_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign rdata = mem_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wp_ff] <= wdata;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && !full) wp_ff <= ~wp_ff;
         if (pop && !empty) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push && !full) - 2'(pop && !empty);
      end
   end
endmodule
`default_nettype wire

// ===== src/lma_back.sv =====
// Back end: nearest-entry search over the map RAMs, merge or append.
// Depends on lma_pkg and lma_ram.
`default_nettype none
module lma_back import lma_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   output logic                    q_pop,
   input  wire point_type          q_data,
   input  wire logic        [23:0] match_dist_sq,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic             [7:0]  rsp_cone_id,
   output logic             [1:0]  rsp_status,
   output logic signed      [23:0] rsp_global_x,
   output logic signed      [23:0] rsp_global_y,
   output logic signed      [17:0] rsp_global_z,
   output logic signed      [18:0] rsp_base_x,
   output logic signed      [17:0] rsp_base_y,
   output logic                    rsp_frame_done
);
   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIFF, S_SQ, S_CMP, S_DECIDE, S_OUT}
      state_type;
   state_type state_ff;
   point_type pt_ff;
   logic [CNT_W-1:0] entry_ff, search_ff, addr_ff, cur_ff;
   logic [IDX_W-1:0] best_ff;
   logic found_ff;
   logic [48:0] best_d_ff;
   logic signed [24:0] dx_ff, dy_ff;
   logic [49:0] dxx_ff, dyy_ff;
   logic [48:0] dsum;
   logic [23:0] bestx_ff, besty_ff;
   logic [23:0] cur_x_ff, cur_y_ff;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [23:0] wx, wy, rdx, rdy;
   logic signed [24:0] mx, my;

   lma_ram #(.WIDTH(24), .DEPTH(MAP_DEPTH)) u_ram_x (
      .clock, .wr_en, .wr_addr, .wr_data(wx), .rd_addr, .rd_data(rdx));
   lma_ram #(.WIDTH(24), .DEPTH(MAP_DEPTH)) u_ram_y (
      .clock, .wr_en, .wr_addr, .wr_data(wy), .rd_addr, .rd_data(rdy));

   assign rd_addr = addr_ff[IDX_W-1:0];
   assign q_pop = (state_ff == S_IDLE) && !q_empty;
   assign rsp_empty = (state_ff != S_OUT);
   assign dsum = 49'(dxx_ff) + 49'(dyy_ff);
   assign mx = (25'(signed'(bestx_ff)) + 25'(pt_ff.gx)) >>> 1;
   assign my = (25'(signed'(besty_ff)) + 25'(pt_ff.gy)) >>> 1;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = best_ff;
      wx = 24'(mx);
      wy = 24'(my);
      if (state_ff == S_DECIDE) begin
         if (found_ff && best_d_ff <= 49'(match_dist_sq)) begin
            wr_en = 1'b1;
         end else if (entry_ff < CNT_W'(MAP_DEPTH)) begin
            wr_en = 1'b1;
            wr_addr = entry_ff[IDX_W-1:0];
            wx = pt_ff.gx;
            wy = pt_ff.gy;
         end
      end
   end

   // Entries are read one at a time; each read feeds a sequence of subtract,
   // square and compare that finishes before the next entry is read.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         entry_ff <= '0;
         search_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               addr_ff <= '0;
               found_ff <= 1'b0;
               if (!q_empty) begin
                  pt_ff <= q_data;
                  state_ff <= (search_ff == '0) ? S_DECIDE : S_SCAN;
               end
            end
            S_SCAN: begin
               cur_ff <= addr_ff;
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               dx_ff <= 25'(signed'(rdx)) - 25'(pt_ff.gx);
               dy_ff <= 25'(signed'(rdy)) - 25'(pt_ff.gy);
               state_ff <= S_SQ;
            end
            S_SQ: begin
               dxx_ff <= 50'(dx_ff * dx_ff);
               dyy_ff <= 50'(dy_ff * dy_ff);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (!found_ff || dsum < best_d_ff) begin
                  found_ff <= 1'b1;
                  best_d_ff <= dsum;
                  best_ff <= cur_ff[IDX_W-1:0];
               end
               addr_ff <= cur_ff + 1'b1;
               state_ff <= (cur_ff + 1'b1 == search_ff) ? S_DECIDE : S_SCAN;
            end
            S_DECIDE: begin
               // The merge uses the best entry's position captured during the search.
               rsp_global_z <= pt_ff.pz;
               rsp_base_x <= pt_ff.bx;
               rsp_base_y <= pt_ff.by;
               rsp_frame_done <= pt_ff.fend;
               if (found_ff && best_d_ff <= 49'(match_dist_sq)) begin
                  rsp_status <= STATUS_MATCH;
                  rsp_cone_id <= 8'(best_ff);
                  rsp_global_x <= 24'(mx);
                  rsp_global_y <= 24'(my);
               end else if (entry_ff < CNT_W'(MAP_DEPTH)) begin
                  rsp_status <= STATUS_NEW;
                  rsp_cone_id <= 8'(entry_ff);
                  rsp_global_x <= pt_ff.gx;
                  rsp_global_y <= pt_ff.gy;
                  entry_ff <= entry_ff + 1'b1;
               end else begin
                  rsp_status <= STATUS_FULL;
                  rsp_cone_id <= 8'd0;
                  rsp_global_x <= pt_ff.gx;
                  rsp_global_y <= pt_ff.gy;
               end
               if (pt_ff.fend) begin
                  search_ff <= wr_en && !(found_ff && best_d_ff <= 49'(match_dist_sq))
                     ? entry_ff + 1'b1 : entry_ff;
               end
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_pop) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Position of the best entry, captured while the search runs.
   always_ff @(posedge clock) begin
      if (state_ff == S_CMP && (!found_ff || dsum < best_d_ff)) begin
         bestx_ff <= cur_x_ff;
         besty_ff <= cur_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DIFF) begin
         cur_x_ff <= rdx;
         cur_y_ff <= rdy;
      end
   end
endmodule
`default_nettype wire

// ===== src/landmark_map_associator_top.sv =====
// A pose word updates the pose registers and gives no result. A point word reaches
// the result ports through the front end, the two-word queue and a search over the N
// searchable map entries (up to 256), each read, subtracted, squared and compared.
// The front takes a new point only once the last has gone to the queue; the back
// takes a new point only once its last result has been popped.
// Reset is synchronous, active high; the map RAM needs no clearing pass.
`default_nettype none
module landmark_map_associator_top import lma_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic               req_cmd,
   input  wire logic signed [23:0] req_pose_x,
   input  wire logic signed [23:0] req_pose_y,
   input  wire logic        [15:0] req_heading,
   input  wire logic signed [17:0] req_point_x,
   input  wire logic signed [17:0] req_point_y,
   input  wire logic signed [17:0] req_point_z,
   input  wire logic               req_frame_end,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic             [7:0]  rsp_cone_id,
   output logic             [1:0]  rsp_status,
   output logic signed      [23:0] rsp_global_x,
   output logic signed      [23:0] rsp_global_y,
   output logic signed      [17:0] rsp_global_z,
   output logic signed      [18:0] rsp_base_x,
   output logic signed      [17:0] rsp_base_y,
   output logic                    rsp_frame_done,
   input  wire logic               csr_wr_en,
   input  wire logic        [0:0]  csr_index,
   input  wire logic        [23:0] csr_wdata
);
   logic [10:0] sensor_offset_ff;
   logic [23:0] match_dist_ff;
   logic q_push, q_full, q_pop, q_empty;
   point_type q_wdata, q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_offset_ff <= '0;
         match_dist_ff <= MATCH_DIST_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_SENSOR_OFFSET) sensor_offset_ff <= csr_wdata[10:0];
         if (csr_index == CSR_MATCH_DIST_SQ) match_dist_ff <= csr_wdata;
      end
   end

   lma_front u_front (
      .clock, .reset, .req_push, .req_full, .req_cmd, .req_pose_x, .req_pose_y,
      .req_heading, .req_point_x, .req_point_y, .req_point_z, .req_frame_end,
      .sensor_offset(sensor_offset_ff), .q_push, .q_full, .q_data(q_wdata));

   lma_queue u_queue (
      .clock, .reset, .push(q_push), .full(q_full), .wdata(q_wdata),
      .pop(q_pop), .empty(q_empty), .rdata(q_rdata));

   lma_back u_back (
      .clock, .reset, .q_empty, .q_pop, .q_data(q_rdata),
      .match_dist_sq(match_dist_ff), .rsp_empty, .rsp_pop, .rsp_cone_id,
      .rsp_status, .rsp_global_x, .rsp_global_y, .rsp_global_z, .rsp_base_x,
      .rsp_base_y, .rsp_frame_done);
endmodule
`default_nettype wire

// ===== src/lma_checker.sv =====
// Port-level checks of the map associator, bound to the top level.
// Depends on lma_pkg and the assertion macro header.
`default_nettype none
`include "landmark_map_associator_top_macros.svh"
module lma_checker import lma_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [1:0]  rsp_status,
   input wire logic [7:0]  rsp_cone_id
);
   `LMA_ASSERT_IMP(a_status_code, clock, reset, !rsp_empty,
      rsp_status == STATUS_MATCH || rsp_status == STATUS_NEW || rsp_status == STATUS_FULL)
   `LMA_ASSERT_IMP(a_full_id_zero, clock, reset,
      !rsp_empty && rsp_status == STATUS_FULL, rsp_cone_id == 8'd0)
   `LMA_ASSERT_NEXT(a_one_word, clock, reset, !rsp_empty && rsp_pop, rsp_empty)
endmodule

bind landmark_map_associator_top lma_checker u_checker (
   .clock, .reset, .rsp_empty, .rsp_pop, .rsp_status, .rsp_cone_id);
`default_nettype wire
